>>> hdl/rrps_pkg.sv
package rrps_pkg;

	localparam int SLOTS       = 16;
	localparam int IDX_BITS    = $clog2(SLOTS);
	localparam int TAG_BITS    = 8;
	localparam int LENGTH_BITS = 16;
	localparam int TIME_BITS   = 32;
	localparam int SEQ_BITS    = 32;
	localparam int TURN_BITS   = 32;
	localparam int STATUS_BITS = 3;
	localparam int PROD_BITS   = TIME_BITS + LENGTH_BITS;

	// Stream payload widths, already whole bytes.
	localparam int IN_DATA_BITS  = TAG_BITS + LENGTH_BITS;
	localparam int OUT_DATA_BITS = TAG_BITS + TURN_BITS;

	localparam logic [STATUS_BITS-1:0] ST_ADMITTED = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_RAN      = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_DONE     = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_IDLE     = 3'd4;

	localparam logic MODE_ADMIT = 1'b0;

	typedef struct packed {
		logic [TAG_BITS-1:0]    tag;
		logic [LENGTH_BITS-1:0] length;
		logic [LENGTH_BITS-1:0] executed;
		logic [TIME_BITS-1:0]   waited;
		logic [TIME_BITS-1:0]   admit_time;
		logic [SEQ_BITS-1:0]    seq_num;
	} slot_t;

endpackage

>>> hdl/rrps_slot_mem.sv
module rrps_slot_mem
	import rrps_pkg::*;
(
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_addr,
	input  slot_t               wr_data,
	input  logic [IDX_BITS-1:0] rd_addr,
	output slot_t               rd_data
);

	slot_t mem_q [SLOTS];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/rrps_mul.sv
module rrps_mul
	import rrps_pkg::*;
(
	input  logic                   clk,
	input  logic [TIME_BITS-1:0]   a,
	input  logic [LENGTH_BITS-1:0] b,
	output logic [PROD_BITS-1:0]   product
);

	logic [PROD_BITS-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= PROD_BITS'(a) * PROD_BITS'(b);
	end

	assign product = product_q;

endmodule

>>> hdl/response_ratio_preemptive_scheduler.sv
// Preemptive highest-response-ratio-next scheduler over a table of 16 jobs. Each input item
// gives exactly one result item. An admit item passes through S_ADM and S_OUT; its result
// is loaded into the output register as the block returns to idle, so the result becomes
// valid in the same cycle that the input is ready again. A tick scans the table with one
// shared 32x16 multiplier. An empty slot passes through read and advance, the first occupied
// slot through read, a multiply and advance, and every further occupied slot through read,
// two multiplies, compare and advance. If any slot is occupied, a second pass then updates
// the waiting counts, visiting S_URD for an empty slot and S_URD and S_UWR for a full one.
// The input is not ready while an item is being worked on. A finished result waits in the
// output register, so the next item can be taken before the result is collected.
module response_ratio_preemptive_scheduler
	import rrps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // job_tag, run_length
	input  logic [0:0]               s_tuser,   // mode
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // chosen_tag, turnaround
	output logic [STATUS_BITS-1:0]   m_tuser    // status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ADM   = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_MUL1  = 4'd3;
	localparam logic [3:0] S_MUL2  = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_NEXT  = 4'd6;
	localparam logic [3:0] S_URD   = 4'd7;
	localparam logic [3:0] S_UWR   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]             state_q;
	logic [SLOTS-1:0]       valid_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	logic                   have_best_q;
	logic [TIME_BITS-1:0]   best_w_q;
	logic [LENGTH_BITS-1:0] best_len_q;
	logic [SEQ_BITS-1:0]    best_age_q;
	logic [SEQ_BITS-1:0]    age_q;
	logic [PROD_BITS-1:0]   pa_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [SEQ_BITS-1:0]    admit_cnt_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic [LENGTH_BITS-1:0] len_q;

	logic [STATUS_BITS-1:0] res_status_q;
	logic [TAG_BITS-1:0]    res_tag_q;
	logic [TURN_BITS-1:0]   res_turn_q;
	logic                   m_valid_q;
	logic [STATUS_BITS-1:0] m_status_q;
	logic [TAG_BITS-1:0]    m_tag_q;
	logic [TURN_BITS-1:0]   m_turn_q;

	logic                   free_found;
	logic [IDX_BITS-1:0]    free_idx;
	logic                   mem_wr_en;
	logic [IDX_BITS-1:0]    mem_wr_addr;
	slot_t                  mem_wr_data;
	slot_t                  rd_data;
	logic [TIME_BITS-1:0]   mul_a;
	logic [LENGTH_BITS-1:0] mul_b;
	logic [PROD_BITS-1:0]   product;
	logic                   beats;
	logic                   last_idx;
	logic [LENGTH_BITS-1:0] exec_inc;
	logic [TIME_BITS-1:0]   turn_full;

	rrps_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	rrps_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (product)
	);

	// Lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_BITS'(i);
			end
		end
	end

	assign last_idx  = (idx_q == IDX_BITS'(SLOTS - 1));
	assign exec_inc  = rd_data.executed + LENGTH_BITS'(1);
	assign turn_full = time_q + TIME_BITS'(1) - rd_data.admit_time;

	// The first multiply forms waited(slot) * length(best), the second waited(best) * length(slot).
	assign mul_a = (state_q == S_MUL1) ? rd_data.waited : best_w_q;
	assign mul_b = (state_q == S_MUL1) ? best_len_q : rd_data.length;

	// Higher ratio wins, then less waiting, then the older admission.
	always_comb begin
		if (pa_q != product) begin
			beats = (pa_q > product);
		end else if (rd_data.waited != best_w_q) begin
			beats = (rd_data.waited < best_w_q);
		end else begin
			beats = (age_q > best_age_q);
		end
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = rd_data;
		case (state_q)
			S_ADM: begin
				mem_wr_en              = free_found;
				mem_wr_addr            = free_idx;
				mem_wr_data.tag        = tag_q;
				mem_wr_data.length     = (len_q == '0) ? LENGTH_BITS'(1) : len_q;
				mem_wr_data.executed   = '0;
				mem_wr_data.waited     = '0;
				mem_wr_data.admit_time = time_q;
				mem_wr_data.seq_num    = admit_cnt_q;
			end
			S_UWR: begin
				mem_wr_en = 1'b1;
				if (idx_q == best_idx_q) begin
					mem_wr_data.executed = exec_inc;
				end else if (rd_data.waited != '1) begin
					mem_wr_data.waited = rd_data.waited + TIME_BITS'(1);
				end
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			idx_q       <= '0;
			have_best_q <= 1'b0;
			time_q      <= '0;
			admit_cnt_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// In S_OUT the output register is reloaded below instead.
			if (m_valid_q && m_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						tag_q       <= s_tdata[TAG_BITS-1:0];
						len_q       <= s_tdata[TAG_BITS +: LENGTH_BITS];
						idx_q       <= '0;
						have_best_q <= 1'b0;
						state_q     <= (s_tuser[0] == MODE_ADMIT) ? S_ADM : S_RD;
					end
				end
				S_ADM: begin
					res_tag_q  <= tag_q;
					res_turn_q <= '0;
					if (free_found) begin
						valid_q[free_idx] <= 1'b1;
						admit_cnt_q       <= admit_cnt_q + SEQ_BITS'(1);
						res_status_q      <= ST_ADMITTED;
					end else begin
						res_status_q <= ST_FULL;
					end
					state_q <= S_OUT;
				end
				S_RD: begin
					state_q <= valid_q[idx_q] ? S_MUL1 : S_NEXT;
				end
				S_MUL1: begin
					age_q <= admit_cnt_q - rd_data.seq_num;
					if (!have_best_q) begin
						have_best_q <= 1'b1;
						best_idx_q  <= idx_q;
						best_w_q    <= rd_data.waited;
						best_len_q  <= rd_data.length;
						best_age_q  <= admit_cnt_q - rd_data.seq_num;
						state_q     <= S_NEXT;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					pa_q    <= product;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (beats) begin
						best_idx_q <= idx_q;
						best_w_q   <= rd_data.waited;
						best_len_q <= rd_data.length;
						best_age_q <= age_q;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (!last_idx) begin
						idx_q   <= idx_q + IDX_BITS'(1);
						state_q <= S_RD;
					end else if (have_best_q) begin
						idx_q   <= '0;
						state_q <= S_URD;
					end else begin
						res_status_q <= ST_IDLE;
						res_tag_q    <= '0;
						res_turn_q   <= '0;
						time_q       <= time_q + TIME_BITS'(1);
						state_q      <= S_OUT;
					end
				end
				S_URD: begin
					if (valid_q[idx_q]) begin
						state_q <= S_UWR;
					end else if (last_idx) begin
						time_q  <= time_q + TIME_BITS'(1);
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + IDX_BITS'(1);
					end
				end
				S_UWR: begin
					if (idx_q == best_idx_q) begin
						res_tag_q <= rd_data.tag;
						if (exec_inc == rd_data.length) begin
							valid_q[idx_q] <= 1'b0;
							res_status_q   <= ST_DONE;
							res_turn_q     <= TURN_BITS'(turn_full);
						end else begin
							res_status_q <= ST_RAN;
							res_turn_q   <= '0;
						end
					end
					if (last_idx) begin
						time_q  <= time_q + TIME_BITS'(1);
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + IDX_BITS'(1);
						state_q <= S_URD;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_tag_q    <= res_tag_q;
						m_turn_q   <= res_turn_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_turn_q, m_tag_q};
	assign m_tuser  = m_status_q;

endmodule

>>> dv/tb_response_ratio_preemptive_scheduler.sv
`timescale 1ns / 1ps

module tb_response_ratio_preemptive_scheduler;
	import rrps_pkg::*;

	localparam logic MODE_TICK   = 1'b1;
	// Even with every result held up by the longest receiver stall, the run
	// stays far below this limit.
	localparam int   CYCLE_LIMIT = 2_000_000;
	localparam int   TAIL_CYCLES = 150;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [TAG_BITS-1:0]    tag;
		logic [TURN_BITS-1:0]   turnaround;
	} outcome_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // job_tag, run_length
	logic [0:0]               s_tuser  = '0;   // mode
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;         // chosen_tag, turnaround
	logic [STATUS_BITS-1:0]   m_tuser;         // status

	// Job table as the testbench tracks it.
	logic                   job_live  [SLOTS];
	logic [TAG_BITS-1:0]    job_tag   [SLOTS];
	logic [LENGTH_BITS-1:0] job_len   [SLOTS];
	logic [LENGTH_BITS-1:0] job_ran   [SLOTS];
	logic [TIME_BITS-1:0]   job_wait  [SLOTS];
	logic [TIME_BITS-1:0]   job_t0    [SLOTS];
	logic [SEQ_BITS-1:0]    job_order [SLOTS];
	logic [SEQ_BITS-1:0]    admit_seq;
	logic [TIME_BITS-1:0]   sched_time;

	outcome_t pending_outcomes[$];
	int       errors       = 0;
	int       items_sent   = 0;
	int       status_count [5] = '{default: 0};
	int       cycle_count  = 0;
	int       tx_gaps      = 1;
	int       burst_left   = 1;
	int       rx_style     = 1;
	int       stall_left   = 0;

	response_ratio_preemptive_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, pending_outcomes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// True if the job in slot a has priority over the job in slot b.
	function automatic bit outranks(int a, int b);
		logic [63:0]         prod_a;
		logic [63:0]         prod_b;
		logic [SEQ_BITS-1:0] age_a;
		logic [SEQ_BITS-1:0] age_b;
		prod_a = 64'(job_wait[a]) * 64'(job_len[b]);
		prod_b = 64'(job_wait[b]) * 64'(job_len[a]);
		if (prod_a != prod_b)
			return prod_a > prod_b;
		if (job_wait[a] != job_wait[b])
			return job_wait[a] < job_wait[b];
		age_a = admit_seq - job_order[a];
		age_b = admit_seq - job_order[b];
		return age_a > age_b;
	endfunction

	function automatic int count_live();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (job_live[i])
				n++;
		return n;
	endfunction

	function automatic void predict_schedule(logic mode, logic [TAG_BITS-1:0] tag,
			logic [LENGTH_BITS-1:0] len);
		outcome_t res;
		int       pick;
		res  = '0;
		pick = -1;
		if (mode == MODE_ADMIT) begin
			for (int i = 0; i < SLOTS; i++)
				if (!job_live[i] && pick < 0)
					pick = i;
			res.tag = tag;
			if (pick < 0) begin
				res.status = ST_FULL;
			end else begin
				res.status      = ST_ADMITTED;
				job_live[pick]  = 1'b1;
				job_tag[pick]   = tag;
				job_len[pick]   = (len == '0) ? LENGTH_BITS'(1) : len;
				job_ran[pick]   = '0;
				job_wait[pick]  = '0;
				job_t0[pick]    = sched_time;
				job_order[pick] = admit_seq;
				admit_seq       = admit_seq + 1'b1;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (job_live[i] && (pick < 0 || outranks(i, pick)))
					pick = i;
			if (pick < 0) begin
				res.status = ST_IDLE;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (job_live[i] && i != pick && job_wait[i] != '1)
						job_wait[i] = job_wait[i] + 1'b1;
				job_ran[pick] = job_ran[pick] + 1'b1;
				res.tag       = job_tag[pick];
				if (job_ran[pick] == job_len[pick]) begin
					res.status     = ST_DONE;
					res.turnaround = TURN_BITS'(sched_time + 1'b1 - job_t0[pick]);
					job_live[pick] = 1'b0;
				end else begin
					res.status = ST_RAN;
				end
			end
			sched_time = sched_time + 1'b1;
		end
		pending_outcomes = {pending_outcomes, res};
		status_count[res.status]++;
	endfunction

	always @(posedge clk) begin : check_results
		outcome_t seen;
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = '{m_tuser, m_tdata[TAG_BITS-1:0], m_tdata[OUT_DATA_BITS-1:TAG_BITS]};
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d tag %0d turn %0d",
					$time, seen.status, seen.tag, seen.turnaround);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (seen.status != want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, seen.status);
					errors++;
				end
				if (seen.tag != want.tag) begin
					$display("%0t: chosen_tag mismatch, expected %0d, got %0d",
						$time, want.tag, seen.tag);
					errors++;
				end
				if (seen.turnaround != want.turnaround) begin
					$display("%0t: turnaround mismatch, expected %0d, got %0d",
						$time, want.turnaround, seen.turnaround);
					errors++;
				end
			end
		end
	end

	// The receiver either takes every result, drops single cycles, or stalls in long runs.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_style == 1 && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
		end else if (rx_style == 2 && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 19);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(logic mode, logic [TAG_BITS-1:0] tag, logic [LENGTH_BITS-1:0] len);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {len, tag};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_schedule(mode, tag, len);
		items_sent++;
		if (tx_gaps != 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= IN_DATA_BITS'($urandom);
				s_tuser  <= 1'($urandom);
				repeat ($urandom_range(0, 5))
					@(negedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_idle_tick();
		// The tag and length of a tick are garbage and must be ignored.
		send_item(MODE_TICK, 8'hA5, 16'h1234);
	endtask

	task automatic test_admit_extremes();
		// A zero length runs as one unit; the all-ones job stays for the whole run.
		send_item(MODE_ADMIT, 8'h00, 16'h0000);
		send_item(MODE_ADMIT, 8'hFF, 16'hFFFF);
		repeat (3)
			send_item(MODE_TICK, 8'h5A, 16'hFFFF);
	endtask

	task automatic test_ratio_ties();
		// Two identical jobs tie on ratio and waiting time, so admission order decides.
		send_item(MODE_ADMIT, 8'h11, 16'd3);
		send_item(MODE_ADMIT, 8'h22, 16'd3);
		repeat (4)
			send_item(MODE_TICK, 8'h00, 16'h0000);
	endtask

	task automatic test_full_table();
		while (count_live() < SLOTS)
			send_item(MODE_ADMIT, TAG_BITS'($urandom), LENGTH_BITS'($urandom_range(1, 4)));
		send_item(MODE_ADMIT, 8'hA5, 16'h5A5A);
	endtask

	task automatic test_random_schedule(int count);
		int                     live;
		int                     long_jobs;
		int                     pct;
		bit                     admit;
		logic [LENGTH_BITS-1:0] len;
		for (int n = 0; n < count; n++) begin
			live      = 0;
			long_jobs = 0;
			for (int i = 0; i < SLOTS; i++)
				if (job_live[i]) begin
					live++;
					if (job_len[i] > 1000)
						long_jobs++;
				end
			// Favor ticks when the table is nearly full so that jobs keep completing.
			admit = $urandom_range(0, 99) < ((live >= SLOTS - 2) ? 15 : 40);
			pct   = $urandom_range(0, 99);
			if (pct < 80)
				len = LENGTH_BITS'($urandom_range(1, 8));
			else if (pct < 95)
				len = LENGTH_BITS'($urandom_range(9, 64));
			else if (pct < 97)
				len = '0;
			else if (long_jobs < 3)
				len = LENGTH_BITS'($urandom_range(1024, 65535));
			else
				len = LENGTH_BITS'($urandom_range(1, 8));
			send_item(admit ? MODE_ADMIT : MODE_TICK, TAG_BITS'($urandom), len);
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++)
			job_live[i] = 1'b0;
		admit_seq  = '0;
		sched_time = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_gaps  = 1;
		rx_style = 1;
		test_idle_tick();
		test_admit_extremes();
		test_ratio_ties();
		test_full_table();
		wait_drained();

		tx_gaps  = 0;
		rx_style = 0;
		test_random_schedule(300);
		wait_drained();
		tx_gaps  = 1;
		rx_style = 1;
		test_random_schedule(300);
		wait_drained();
		rx_style = 2;
		test_random_schedule(300);
		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Sent %0d items; results: %0d admitted, %0d refused on a full table,",
			items_sent, status_count[ST_ADMITTED], status_count[ST_FULL]);
		$display("%0d ticks ran a job, %0d completed one, %0d idle ticks; %0d mismatches.",
			status_count[ST_RAN], status_count[ST_DONE], status_count[ST_IDLE], errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
